@@ sv/hrs_pkg.sv @@
`timescale 1ns / 1ps

package hrs_pkg;

    localparam int PAT_BITS = 120;

    // match patterns, right-aligned, first character in the highest byte of each pattern
    localparam logic [PAT_BITS-1:0] CL_PAT    = "content-length:";
    localparam logic [PAT_BITS-1:0] CONN_PAT  = "connection:";
    localparam logic [PAT_BITS-1:0] CLOSE_PAT = "close";
    localparam logic [PAT_BITS-1:0] HTTP_PAT  = "HTTP/";

    localparam int CL_LEN    = 15;
    localparam int CONN_LEN  = 11;
    localparam int CLOSE_LEN = 5;
    localparam int HTTP_LEN  = 5;

    localparam logic [9:0]  CODE_CAP       = 10'd1000;
    localparam logic [9:0]  CODE_OK_LO     = 10'd200;
    localparam logic [9:0]  CODE_OK_HI     = 10'd300;
    localparam logic [31:0] STATUS_WINDOW  = 32'd12;
    localparam logic [31:0] MIN_CACHE_SIZE = 32'd12;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef struct packed {
        logic neg;
        logic close;
        logic conn_checked;
        logic cl_done;
        logic cl_digits;
        logic prefix_bad;
        logic crlf;
        logic hdr;
    } flags_t;

    typedef struct packed {
        logic        header_found;
        logic [31:0] header_length;
        logic [31:0] declared_length;
        logic        body_complete;
        logic        response_done;
        logic        cacheable;
    } result_t;

    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= "A" && c <= "Z")
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic [7:0] pat_char(input logic [PAT_BITS-1:0] pat, input int len,
                                            input int i);
        logic [7:0] c;
        c = '0;
        if (i >= 0 && i < len)
        begin
            c = pat[8*(len-1-i) +: 8];
        end
        return c;
    endfunction

    // substring matcher: longest pattern prefix that ends at this character
    function automatic logic [3:0] match_step(input logic [PAT_BITS-1:0] pat, input int len,
                                              input logic [3:0] pos, input logic [7:0] ch);
        logic [3:0] res;
        logic       ok;
        int         p;
        res = '0;
        for (int k = 1; k <= 15; k++)
        begin
            if (k <= len && k <= int'(pos) + 1 && pat_char(pat, len, k - 1) == ch)
            begin
                ok = 1'b1;
                for (int j = 0; j < 14; j++)
                begin
                    if (j < k - 1)
                    begin
                        p = int'(pos) - k + 1 + j;
                        if (pat_char(pat, len, j) != pat_char(pat, len, p))
                        begin
                            ok = 1'b0;
                        end
                    end
                end
                if (ok)
                begin
                    res = 4'(k);
                end
            end
        end
        return res;
    endfunction

endpackage

@@ sv/hrs_stream_if.sv @@
`timescale 1ns / 1ps

interface hrs_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ sv/hrs_result_if.sv @@
`timescale 1ns / 1ps

interface hrs_result_if;
    logic        valid;
    logic        ready;
    logic        header_found;
    logic [31:0] header_length;
    logic [31:0] declared_length;
    logic        body_complete;
    logic        response_done;
    logic        cacheable;

    modport source (output valid, output header_found, output header_length,
                    output declared_length, output body_complete, output response_done,
                    output cacheable, input ready);
    modport sink   (input valid, input header_found, input header_length,
                    input declared_length, input body_complete, input response_done,
                    input cacheable, output ready);
endinterface

@@ sv/hrs_core.sv @@
`timescale 1ns / 1ps

module hrs_core
    import hrs_pkg::*;
#(
    parameter int LENGTH_BITS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output result_t    result
);

    localparam int LW = LENGTH_BITS + 4;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_SKIP,
        PH_DIGITS,
        PH_END
    } phase_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_CR,
        T_CRLF,
        T_CRLFCR,
        T_LF
    } term_t;

    logic [31:0]            byte_count_reg, byte_count_next;
    logic [31:0]            header_end_reg, header_end_next;
    logic [LENGTH_BITS-1:0] length_reg, length_next;
    term_t                  term_reg, term_next;
    logic [3:0]             cl_pos_reg, cl_pos_next;
    logic [3:0]             conn_pos_reg, conn_pos_next;
    logic [2:0]             close_pos_reg, close_pos_next;
    phase_t                 phase_reg, phase_next;
    logic [9:0]             code_reg, code_next;
    flags_t                 flags_reg, flags_next;

    logic [7:0]  lc;
    logic [3:0]  digit;
    logic [13:0] code_wide;
    logic [LW-1:0] len_wide;
    logic [63:0] len64;
    logic [31:0] body;
    logic        full;
    logic        two_xx;

    always_comb
    begin
        lc              = fold(data_byte);
        digit           = data_byte[3:0];
        byte_count_next = (byte_count_reg == '1) ? byte_count_reg : byte_count_reg + 32'd1;
        header_end_next = header_end_reg;
        length_next     = length_reg;
        term_next       = term_reg;
        cl_pos_next     = cl_pos_reg;
        conn_pos_next   = conn_pos_reg;
        close_pos_next  = close_pos_reg;
        phase_next      = phase_reg;
        code_next       = code_reg;
        flags_next      = flags_reg;
        code_wide = {code_reg, 4'b0} - {2'b0, code_reg, 2'b0} - {2'b0, code_reg, 2'b0}
                  + {3'b0, code_reg, 1'b0} + {10'b0, digit};
        len_wide  = ({4'b0, length_reg} << 3) + ({4'b0, length_reg} << 1) + LW'(digit);

        if (byte_count_reg < 32'(HTTP_LEN) &&
            data_byte != pat_char(HTTP_PAT, HTTP_LEN, int'(byte_count_reg[2:0])))
        begin
            flags_next.prefix_bad = 1'b1;
        end

        // status code after the first space of the status line
        case (phase_reg)
            PH_WAIT:
            begin
                if (byte_count_reg < STATUS_WINDOW && data_byte == CH_SPACE)
                begin
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                if (data_byte == CH_SPACE || data_byte == CH_TAB || data_byte == CH_LF ||
                    data_byte == CH_CR || data_byte == CH_VT || data_byte == CH_FF)
                begin
                    phase_next = PH_SKIP;
                end
                else if (data_byte == CH_PLUS)
                begin
                    phase_next = PH_DIGITS;
                end
                else if (data_byte == CH_MINUS)
                begin
                    flags_next.neg = 1'b1;
                    phase_next     = PH_DIGITS;
                end
                else if (is_digit(data_byte))
                begin
                    code_next  = 10'(digit);
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    phase_next = PH_END;
                end
            end
            PH_DIGITS:
            begin
                if (is_digit(data_byte))
                begin
                    code_next = (code_wide > 14'(CODE_CAP)) ? CODE_CAP : code_wide[9:0];
                end
                else
                begin
                    phase_next = PH_END;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        // content-length value, only before the header end
        if (!(flags_reg.hdr || flags_reg.cl_done))
        begin
            if (cl_pos_reg < 4'(CL_LEN))
            begin
                cl_pos_next = match_step(CL_PAT, CL_LEN, cl_pos_reg, lc);
            end
            else if (!flags_reg.cl_digits)
            begin
                if (is_digit(data_byte))
                begin
                    length_next          = LENGTH_BITS'(digit);
                    flags_next.cl_digits = 1'b1;
                end
                else if (data_byte != CH_SPACE && data_byte != CH_TAB)
                begin
                    flags_next.cl_done = 1'b1;
                end
            end
            else if (is_digit(data_byte))
            begin
                length_next = (len_wide[LW-1:LENGTH_BITS] != '0) ? '1
                                                                 : len_wide[LENGTH_BITS-1:0];
            end
            else
            begin
                flags_next.cl_done = 1'b1;
            end
        end

        // connection: close, looked for until a CRLF blank line (a bare LF blank line does not stop it)
        if (!(flags_reg.crlf || flags_reg.conn_checked))
        begin
            if (conn_pos_reg < 4'(CONN_LEN))
            begin
                conn_pos_next = match_step(CONN_PAT, CONN_LEN, conn_pos_reg, lc);
            end
            else if (close_pos_reg == '0 && (data_byte == CH_SPACE || data_byte == CH_TAB))
            begin
                close_pos_next = close_pos_reg;
            end
            else if (close_pos_reg < 3'(CLOSE_LEN) &&
                     lc == pat_char(CLOSE_PAT, CLOSE_LEN, int'(close_pos_reg)))
            begin
                close_pos_next = close_pos_reg + 3'd1;
                if (close_pos_next >= 3'(CLOSE_LEN))
                begin
                    flags_next.close        = 1'b1;
                    flags_next.conn_checked = 1'b1;
                end
            end
            else
            begin
                flags_next.conn_checked = 1'b1;
            end
        end

        // header terminator: CRLFCRLF, CRLF followed by a bare LF, or a bare LFLF
        if (data_byte == CH_CR)
        begin
            term_next = (term_reg == T_CRLF) ? T_CRLFCR : T_CR;
        end
        else if (data_byte == CH_LF)
        begin
            term_next = T_LF;
            case (term_reg)
                T_CR:
                begin
                    term_next = T_CRLF;
                end
                T_CRLFCR:
                begin
                    flags_next.crlf = 1'b1;
                    if (!flags_reg.hdr)
                    begin
                        flags_next.hdr  = 1'b1;
                        header_end_next = byte_count_next;
                    end
                end
                T_CRLF, T_LF:
                begin
                    if (!flags_reg.hdr)
                    begin
                        flags_next.hdr  = 1'b1;
                        header_end_next = byte_count_next;
                    end
                end
                default:
                begin
                    term_next = T_LF;
                end
            endcase
        end
        else
        begin
            term_next = T_IDLE;
        end

        // a header found with this very byte leaves no body yet, so the
        // completeness test can use the stored length and header end
        body   = byte_count_next - header_end_reg;
        full   = flags_reg.hdr && (length_reg != '0) &&
                 ({32'b0, body} >= 64'(length_reg));
        two_xx = (phase_next == PH_DIGITS || phase_next == PH_END) && !flags_next.neg &&
                 code_next >= CODE_OK_LO && code_next < CODE_OK_HI;
        len64  = 64'(length_next);

        result.header_found    = flags_next.hdr;
        result.header_length   = flags_next.hdr ? header_end_next : '0;
        result.declared_length = !flags_next.hdr ? '0
                               : (len64[63:32] != '0) ? '1 : len64[31:0];
        result.body_complete   = full;
        result.response_done   = full || last_byte;
        result.cacheable       = full && byte_count_next >= MIN_CACHE_SIZE &&
                                 !flags_next.prefix_bad && two_xx && !flags_next.close;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            header_end_reg <= '0;
            length_reg     <= '0;
            term_reg       <= T_IDLE;
            cl_pos_reg     <= '0;
            conn_pos_reg   <= '0;
            close_pos_reg  <= '0;
            phase_reg      <= PH_WAIT;
            code_reg       <= '0;
            flags_reg      <= '0;
        end
        else if (accept)
        begin
            byte_count_reg <= byte_count_next;
            header_end_reg <= header_end_next;
            length_reg     <= length_next;
            term_reg       <= term_next;
            cl_pos_reg     <= cl_pos_next;
            conn_pos_reg   <= conn_pos_next;
            close_pos_reg  <= close_pos_next;
            phase_reg      <= phase_next;
            code_reg       <= code_next;
            flags_reg      <= flags_next;
        end
    end

endmodule

@@ sv/hrs_out_stage.sv @@
`timescale 1ns / 1ps

module hrs_out_stage
    import hrs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  logic    take,
    input  result_t data,
    output logic    valid,
    output result_t q
);

    logic    valid_reg;
    result_t q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= data;
        end
    end

    assign valid = valid_reg;
    assign q     = q_reg;

endmodule

@@ sv/http_response_header_scanner.sv @@
`timescale 1ns / 1ps

// http response header scanner
// stream: one response byte per transaction (data_byte, last_byte marks the
//   origin closing after this byte)
// result: one transaction per input byte with header_found, header_length,
//   declared_length, body_complete, response_done and cacheable, each judged
//   on all bytes received so far
// output: the result for a byte is registered and valid in the cycle after its transaction
// throughput: one byte per cycle while no result is stalled; the matchers,
//   counters and status parser all update in the cycle the byte is taken and
//   their outputs land in the result register
// stalls: while a result waits on result.ready, stream.ready stays high only
//   if that result is being taken in the same cycle
// reset: clears the byte count, all matchers and flags and the result valid;
//   the block is ready for the first byte right after reset
// LENGTH_BITS sets the width of the stored content-length value, which
//   saturates at its top; the reported value saturates at 32 bits
module http_response_header_scanner
    import hrs_pkg::*;
#(
    parameter int LENGTH_BITS = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    hrs_stream_if.sink   stream,
    hrs_result_if.source result
);

    logic    accept;
    result_t core_result;
    result_t out_q;
    logic    out_valid;

    assign stream.ready = !out_valid || result.ready;
    assign accept       = stream.valid && stream.ready;

    hrs_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (stream.data_byte),
        .last_byte (stream.last_byte),
        .result    (core_result)
    );

    hrs_out_stage u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept),
        .take  (result.ready),
        .data  (core_result),
        .valid (out_valid),
        .q     (out_q)
    );

    assign result.valid           = out_valid;
    assign result.header_found    = out_q.header_found;
    assign result.header_length   = out_q.header_length;
    assign result.declared_length = out_q.declared_length;
    assign result.body_complete   = out_q.body_complete;
    assign result.response_done   = out_q.response_done;
    assign result.cacheable       = out_q.cacheable;

    // a new transaction never overwrites a result that is still stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !(out_valid && !result.ready))
        else $error("input taken over a stalled result");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result.valid)
        else $error("no result after an accepted byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.body_complete |-> result.header_found && result.response_done)
        else $error("body complete without header end");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.cacheable |-> result.body_complete)
        else $error("cacheable without full body");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    typedef struct packed {
        logic        header_found;
        logic [31:0] header_length;
        logic [31:0] declared_length;
        logic        body_complete;
        logic        response_done;
        logic        cacheable;
    } scan_result_t;

    typedef enum logic [1:0] {
        ST_FIND_SPACE,
        ST_SKIP_WS,
        ST_DIGITS,
        ST_DONE
    } status_phase_t;

    typedef enum logic [2:0] {
        TERM_IDLE,
        TERM_CR,
        TERM_CRLF,
        TERM_CRLFCR,
        TERM_LF
    } term_state_t;

    localparam logic [7:0]  C_TAB   = 8'h09;
    localparam logic [7:0]  C_LF    = 8'h0A;
    localparam logic [7:0]  C_VT    = 8'h0B;
    localparam logic [7:0]  C_FF    = 8'h0C;
    localparam logic [7:0]  C_CR    = 8'h0D;
    localparam logic [7:0]  C_SPACE = 8'h20;
    localparam logic [7:0]  C_PLUS  = 8'h2B;
    localparam logic [7:0]  C_MINUS = 8'h2D;
    localparam logic [7:0]  C_ZERO  = 8'h30;
    localparam logic [7:0]  C_NINE  = 8'h39;
    localparam logic [7:0]  C_UPPER_A = 8'h41;
    localparam logic [7:0]  C_UPPER_Z = 8'h5A;
    localparam logic [7:0]  C_LOWER_A = 8'h61;
    localparam logic [7:0]  C_LOWER_Z = 8'h7A;
    localparam logic [63:0] LEN_MAX     = 64'h0000_0000_FFFF_FFFF;
    localparam int          CODE_LIMIT  = 1000;
    localparam int          STATUS_SPAN = 12;
    localparam int          MIN_CACHED  = 12;
    localparam int          TARGET_BYTES = 700;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          CYCLE_LIMIT  = 200000;

    logic clk = 1'b0;
    logic rst_n;

    hrs_stream_if stream_bus ();
    hrs_result_if result_bus ();

    http_response_header_scanner uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_bus),
        .result (result_bus)
    );

    string cl_text    = "content-length:";
    string conn_text  = "connection:";
    string close_text = "close";
    string http_text  = "HTTP/";

    byte_item_t   response_bytes[$];
    scan_result_t scan_results_due[$];
    byte_item_t   next_byte;

    int send_idle_pct;
    int recv_idle_pct;
    logic send_hold;
    int bytes_taken;
    int results_seen;
    int hold_at;
    int hold_left;
    logic hold_done;
    int mismatches;
    int total_bytes;
    int cycle_count;

    // scanner state mirror
    logic [31:0]   seen_count;
    logic [31:0]   hdr_end;
    logic [63:0]   clen_acc;
    term_state_t   term_state;
    int            cl_pos;
    int            conn_pos;
    int            close_pos;
    status_phase_t status_phase;
    logic [9:0]    status_code;
    logic          hdr_seen;
    logic          crlf_seen;
    logic          prefix_bad;
    logic          cl_digits;
    logic          cl_done;
    logic          conn_checked;
    logic          saw_close;
    logic          neg_code;

    always #5 clk = ~clk;

    function automatic logic is_num(input logic [7:0] c);
        return (c >= C_ZERO) && (c <= C_NINE);
    endfunction

    // longest prefix of pat that ends with ch, given pos bytes already matched
    function automatic int advance_match(input string pat, input int pos, input logic [7:0] ch);
        int   k;
        int   res;
        logic ok;
        res = 0;
        for (k = pos + 1; k >= 1 && res == 0; k--)
        begin
            if (pat.getc(k - 1) == ch)
            begin
                ok = 1'b1;
                for (int j = 0; j < k - 1; j++)
                begin
                    if (pat.getc(j) != pat.getc(pos - k + 1 + j))
                    begin
                        ok = 1'b0;
                    end
                end
                if (ok)
                begin
                    res = k;
                end
            end
        end
        return res;
    endfunction

    function automatic scan_result_t scan_byte(input logic [7:0] b, input logic closing);
        logic [7:0]   lc;
        logic [31:0]  idx;
        logic [31:0]  cnt;
        logic [31:0]  body;
        logic [63:0]  clen;
        logic [63:0]  digit;
        int           code;
        logic         full;
        logic         two_xx;
        scan_result_t r;
        lc = b;
        if (b >= C_UPPER_A && b <= C_UPPER_Z)
        begin
            lc = b + 8'd32;
        end
        idx = seen_count;
        cnt = (idx == 32'hFFFF_FFFF) ? idx : idx + 32'd1;
        code = int'(status_code);

        if (idx < 5 && b != http_text.getc(idx))
        begin
            prefix_bad = 1'b1;
        end

        case (status_phase)
            ST_FIND_SPACE:
            begin
                if (idx < STATUS_SPAN && b == C_SPACE)
                begin
                    status_phase = ST_SKIP_WS;
                end
            end
            ST_SKIP_WS:
            begin
                if (b == C_SPACE || b == C_TAB || b == C_LF || b == C_CR || b == C_VT ||
                    b == C_FF)
                begin
                    status_phase = ST_SKIP_WS;
                end
                else if (b == C_PLUS)
                begin
                    status_phase = ST_DIGITS;
                end
                else if (b == C_MINUS)
                begin
                    neg_code = 1'b1;
                    status_phase = ST_DIGITS;
                end
                else if (is_num(b))
                begin
                    code = int'(b - C_ZERO);
                    status_phase = ST_DIGITS;
                end
                else
                begin
                    status_phase = ST_DONE;
                end
            end
            ST_DIGITS:
            begin
                if (is_num(b))
                begin
                    code = code * 10 + int'(b - C_ZERO);
                    if (code > CODE_LIMIT)
                    begin
                        code = CODE_LIMIT;
                    end
                end
                else
                begin
                    status_phase = ST_DONE;
                end
            end
            default:
            begin
                status_phase = ST_DONE;
            end
        endcase
        status_code = code[9:0];

        if (!(hdr_seen || cl_done))
        begin
            if (cl_pos < cl_text.len())
            begin
                cl_pos = advance_match(cl_text, cl_pos, lc);
            end
            else if (!cl_digits)
            begin
                if (is_num(b))
                begin
                    clen_acc = 64'(b - C_ZERO);
                    cl_digits = 1'b1;
                end
                else if (b != C_SPACE && b != C_TAB)
                begin
                    cl_done = 1'b1;
                end
            end
            else if (is_num(b))
            begin
                digit = 64'(b - C_ZERO);
                if (clen_acc > (LEN_MAX - digit) / 10)
                begin
                    clen_acc = LEN_MAX;
                end
                else
                begin
                    clen_acc = clen_acc * 10 + digit;
                end
            end
            else
            begin
                cl_done = 1'b1;
            end
        end

        if (!(crlf_seen || conn_checked))
        begin
            if (conn_pos < conn_text.len())
            begin
                conn_pos = advance_match(conn_text, conn_pos, lc);
            end
            else if (!(close_pos == 0 && (b == C_SPACE || b == C_TAB)))
            begin
                if (lc == close_text.getc(close_pos))
                begin
                    close_pos++;
                    if (close_pos >= close_text.len())
                    begin
                        saw_close = 1'b1;
                        conn_checked = 1'b1;
                    end
                end
                else
                begin
                    conn_checked = 1'b1;
                end
            end
        end

        if (b == C_CR)
        begin
            if (term_state == TERM_CRLF)
            begin
                term_state = TERM_CRLFCR;
            end
            else
            begin
                term_state = TERM_CR;
            end
        end
        else if (b == C_LF)
        begin
            if (term_state == TERM_CR)
            begin
                term_state = TERM_CRLF;
            end
            else
            begin
                if (term_state == TERM_CRLFCR)
                begin
                    crlf_seen = 1'b1;
                end
                if ((term_state == TERM_CRLFCR || term_state == TERM_CRLF ||
                     term_state == TERM_LF) && !hdr_seen)
                begin
                    hdr_seen = 1'b1;
                    hdr_end = cnt;
                end
                term_state = TERM_LF;
            end
        end
        else
        begin
            term_state = TERM_IDLE;
        end

        seen_count = cnt;

        clen = hdr_seen ? clen_acc : 64'd0;
        body = seen_count - hdr_end;
        full = hdr_seen && clen != 0 && {32'd0, body} >= clen;
        two_xx = (status_phase == ST_DIGITS || status_phase == ST_DONE) && !neg_code &&
                 code >= 200 && code < 300;

        r.header_found    = hdr_seen;
        r.header_length   = hdr_seen ? hdr_end : 32'd0;
        r.declared_length = (clen > LEN_MAX) ? 32'hFFFF_FFFF : clen[31:0];
        r.body_complete   = full;
        r.response_done   = full || closing;
        r.cacheable       = full && seen_count >= MIN_CACHED && !prefix_bad && two_xx &&
                            !saw_close;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic string vary_case(input string s);
        string r;
        logic [7:0] c;
        r = s;
        for (int i = 0; i < r.len(); i++)
        begin
            c = r.getc(i);
            if (c >= C_LOWER_A && c <= C_LOWER_Z && $urandom_range(1) == 1)
            begin
                r.putc(i, c - 8'd32);
            end
        end
        return r;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic l);
        byte_item_t item;
        item.data = b;
        item.last = l;
        response_bytes.push_back(item);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_byte(s.getc(i), 1'b0);
        end
    endtask

    task automatic build_response();
        string eol;
        string line;
        string conn_line;
        string len_line;
        string token;
        string junk_chars;
        string body_chars;
        int    extra;
        logic [7:0] b;
        junk_chars = "0123456789 \tcloseCONTENT-length:n";
        body_chars = "\r\n 0:";
        if ($urandom_range(3) == 0)
        begin
            eol = "\n";
        end
        else
        begin
            eol = "\r\n";
        end

        case ($urandom_range(15))
            8:  line = $sformatf("HTTP/1.0 %0d Moved", $urandom_range(300, 599));
            9:  line = $sformatf("HTTP/1.1 %0d Early", $urandom_range(100, 199));
            10: line = "HTTP/1.1 \t+204 No Content";
            11: line = "HTTP/1.1 -200 OK";
            12: line = "http/1.1 200 OK";
            13: line = "HTTP/1.1 2000000 OK";
            14: line = "HTTP/1.10000 200 OK";
            15: line = "HTTP/1.1 x200 OK";
            default: line = $sformatf("HTTP/1.1 %0d OK", $urandom_range(200, 299));
        endcase
        push_text({line, eol});

        // noise lines, some of them partial matches of the keys
        extra = $urandom_range(3);
        for (int n = 0; n < extra; n++)
        begin
            case ($urandom_range(4))
                0: line = "X-Trace";
                1: line = "Conten";
                2: line = "Connectio";
                3: line = "Content-Lengt";
                default: line = "Server";
            endcase
            token = "";
            for (int i = $urandom_range(1, 10); i > 0; i--)
            begin
                token = {token, " "};
                token.putc(token.len() - 1,
                           junk_chars.getc($urandom_range(junk_chars.len() - 1)));
            end
            push_text({vary_case(line), ":", token, eol});
        end

        case ($urandom_range(5))
            0: conn_line = " close";
            1: conn_line = "\t close";
            2: conn_line = " keep-alive";
            3: conn_line = " clos";
            4: conn_line = "close";
            default: conn_line = "";
        endcase
        if (conn_line.len() != 0)
        begin
            conn_line = {vary_case("connection:"), vary_case(conn_line), eol};
        end

        case ($urandom_range(3))
            2: len_line = "content-content-length:";
            3: len_line = "content-lengthh:";
            default: len_line = "content-length:";
        endcase
        case ($urandom_range(9))
            6: len_line = {vary_case(len_line), " \t99999999999999999999", eol};
            7: len_line = {vary_case(len_line), " 0", eol};
            8: len_line = {vary_case(len_line), " abc", eol};
            9: len_line = "";
            default: len_line = {vary_case(len_line), $sformatf(" %0d", $urandom_range(1, 400)),
                                 eol};
        endcase

        if ($urandom_range(1) == 1)
        begin
            push_text({conn_line, len_line});
        end
        else
        begin
            push_text({len_line, conn_line});
        end

        // the blank line is left out now and then so the body has to end the header
        if ($urandom_range(9) != 0)
        begin
            push_text(eol);
        end

        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        while (response_bytes.size() < TARGET_BYTES)
        begin
            if ($urandom_range(5) == 0)
            begin
                b = body_chars.getc($urandom_range(body_chars.len() - 1));
            end
            else
            begin
                b = 8'($urandom_range(255));
            end
            push_byte(b, $urandom_range(24) == 0);
        end
    endtask

    // driver: offers bytes and mirrors every accepted transaction into the scanner model
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_bus.valid     <= 1'b0;
            stream_bus.data_byte <= 8'h00;
            stream_bus.last_byte <= 1'b0;
            bytes_taken  <= 0;
            seen_count   = '0;
            hdr_end      = '0;
            clen_acc     = '0;
            term_state   = TERM_IDLE;
            cl_pos       = 0;
            conn_pos     = 0;
            close_pos    = 0;
            status_phase = ST_FIND_SPACE;
            status_code  = '0;
            hdr_seen     = 1'b0;
            crlf_seen    = 1'b0;
            prefix_bad   = 1'b0;
            cl_digits    = 1'b0;
            cl_done      = 1'b0;
            conn_checked = 1'b0;
            saw_close    = 1'b0;
            neg_code     = 1'b0;
        end
        else
        begin
            if (stream_bus.valid && stream_bus.ready)
            begin
                scan_results_due.push_back(scan_byte(stream_bus.data_byte,
                                                     stream_bus.last_byte));
                bytes_taken <= bytes_taken + 1;
            end
            if (!stream_bus.valid || stream_bus.ready)
            begin
                if (response_bytes.size() != 0 && !send_hold &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    next_byte = response_bytes.pop_front();
                    stream_bus.valid     <= 1'b1;
                    stream_bus.data_byte <= next_byte.data;
                    stream_bus.last_byte <= next_byte.last;
                end
                else
                begin
                    stream_bus.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: drives ready and checks each result transaction
    always @(posedge clk or negedge rst_n)
    begin
        scan_result_t want;
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
            results_seen     <= 0;
            hold_left        <= 0;
            hold_done        <= 1'b0;
        end
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (scan_results_due.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = scan_results_due.pop_front();
                    check_field("header_found", 32'(want.header_found),
                                32'(result_bus.header_found));
                    check_field("header_length", want.header_length,
                                result_bus.header_length);
                    check_field("declared_length", want.declared_length,
                                result_bus.declared_length);
                    check_field("body_complete", 32'(want.body_complete),
                                32'(result_bus.body_complete));
                    check_field("response_done", 32'(want.response_done),
                                32'(result_bus.response_done));
                    check_field("cacheable", 32'(want.cacheable), 32'(result_bus.cacheable));
                end
                results_seen <= results_seen + 1;
            end
            // one long back-pressure stretch while the sender keeps pushing
            if (!hold_done && results_seen == hold_at)
            begin
                hold_done        <= 1'b1;
                hold_left        <= HOLD_CYCLES;
                result_bus.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left        <= hold_left - 1;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= $urandom_range(99) >= recv_idle_pct;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        cycle_count = 0;
        mismatches = 0;
        send_hold = 1'b0;
        send_idle_pct = 17;
        recv_idle_pct = 67;
        build_response();
        total_bytes = response_bytes.size();
        hold_at = 2 * total_bytes / 3 + 30;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_taken < total_bytes / 3)
        begin
            @(posedge clk);
        end
        send_idle_pct <= 67;
        recv_idle_pct <= 17;
        // sender stops until the scanner has drained
        send_hold <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (stream_bus.valid || scan_results_due.size() != 0);
        send_hold <= 1'b0;

        while (bytes_taken < 2 * total_bytes / 3)
        begin
            @(posedge clk);
        end
        send_idle_pct <= 0;
        recv_idle_pct <= 0;

        while (response_bytes.size() != 0 || stream_bus.valid || scan_results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/hrs_pkg.sv
sv/hrs_stream_if.sv
sv/hrs_result_if.sv
sv/hrs_core.sv
sv/hrs_out_stage.sv
sv/http_response_header_scanner.sv
tb/testbench.sv
